[rtl/isq_pkg.sv]
// isq_pkg: shared types, event codes and bus operation codes for the i2c sensor transaction sequencer
// used by isq_front, isq_queue, isq_back and the top level; no dependencies
package isq_pkg;

	localparam logic [2:0] EV_START = 3'd0;
	localparam logic [2:0] EV_ACK   = 3'd1;
	localparam logic [2:0] EV_NACK  = 3'd2;
	localparam logic [2:0] EV_RX    = 3'd3;
	localparam logic [2:0] EV_STOP  = 3'd4;
	localparam logic [2:0] EV_BAD   = 3'd5;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_ACK   = 3'd3;
	localparam logic [2:0] OP_NSTOP = 3'd4;

	typedef struct packed {
		logic [2:0]  ev;
		logic [6:0]  dev_addr;
		logic        read_mode;
		logic [31:0] command_word;
		logic [1:0]  read_extra;
		logic [1:0]  write_extra;
		logic [31:0] tag_in;
		logic [7:0]  rx_byte;
	} item_t;

endpackage

[rtl/isq_front.sv]
// isq_front: decodes an incoming bus event request into a queue item
// depends on isq_pkg
module isq_front (
	input  logic [2:0]     cmd,
	input  logic [6:0]     dev_addr,
	input  logic           read_mode,
	input  logic [31:0]    command_word,
	input  logic [1:0]     read_extra,
	input  logic [1:0]     write_extra,
	input  logic [31:0]    tag_in,
	input  logic [7:0]     rx_byte,
	output isq_pkg::item_t item
);

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_ACK   = 3'd1;
	localparam logic [2:0] CMD_NACK  = 3'd2;
	localparam logic [2:0] CMD_RX    = 3'd3;
	localparam logic [2:0] CMD_STOP  = 3'd4;

	always_comb begin
		item.dev_addr     = dev_addr;
		item.read_mode    = read_mode;
		item.command_word = command_word;
		item.read_extra   = read_extra;
		item.write_extra  = write_extra;
		item.tag_in       = tag_in;
		item.rx_byte      = rx_byte;
		case (cmd)
			CMD_START: item.ev = isq_pkg::EV_START;
			CMD_ACK:   item.ev = isq_pkg::EV_ACK;
			CMD_NACK:  item.ev = isq_pkg::EV_NACK;
			CMD_RX:    item.ev = isq_pkg::EV_RX;
			CMD_STOP:  item.ev = isq_pkg::EV_STOP;
			default:   item.ev = isq_pkg::EV_BAD;
		endcase
	end

endmodule

[rtl/isq_queue.sv]
// isq_queue: two-entry request queue between front and back
// depends on isq_pkg
module isq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  isq_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output isq_pkg::item_t head_item
);

	isq_pkg::item_t ents_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = ents_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ents_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/isq_back.sv]
// isq_back: transaction phase machine and registered result stage
// depends on isq_pkg
module isq_back #(
	parameter int WORD_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  isq_pkg::item_t head_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     bus_op,
	output logic           tx_valid,
	output logic [7:0]     tx_byte,
	output logic           done_res,
	output logic [31:0]    read_word,
	output logic [31:0]    tag_out,
	output logic           fault,
	output logic           busy_flag
);

	localparam int AW = 8 * WORD_BYTES;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_INIT  = 3'd1;
	localparam logic [2:0] PH_SETR  = 3'd2;
	localparam logic [2:0] PH_HOLD  = 3'd3;
	localparam logic [2:0] PH_RX    = 3'd4;
	localparam logic [2:0] PH_WX    = 3'd5;
	localparam logic [2:0] PH_CLOSE = 3'd6;

	logic [2:0]    phase_q, phase_d;
	logic [6:0]    addr_q, addr_d;
	logic          dir_q, dir_d;
	logic [31:0]   command_q, command_d;
	logic [1:0]    writes_left_q, writes_left_d;
	logic [1:0]    reads_left_q, reads_left_d;
	logic [AW-1:0] accum_q, accum_d;
	logic [31:0]   tag_q, tag_d;

	logic [2:0]    op_d;
	logic          txv_d, done_d, fault_d;
	logic [7:0]    txb_d;
	logic [31:0]   rword_d, tout_d;
	logic [1:0]    wl_dec;
	logic [AW+7:0] acc_shift;

	logic          out_valid_q;
	logic [2:0]    bus_op_q;
	logic          tx_valid_q, done_q, fault_q, busy_q;
	logic [7:0]    tx_byte_q;
	logic [31:0]   read_word_q, tag_out_q;

	assign pop = head_valid && (!out_valid_q || !out_stall);

	assign wl_dec    = writes_left_q - 2'd1;
	assign acc_shift = {accum_q | AW'(head_item.rx_byte), 8'h00};

	always_comb begin
		phase_d       = phase_q;
		addr_d        = addr_q;
		dir_d         = dir_q;
		command_d     = command_q;
		writes_left_d = writes_left_q;
		reads_left_d  = reads_left_q;
		accum_d       = accum_q;
		tag_d         = tag_q;
		op_d          = isq_pkg::OP_NONE;
		txv_d         = 1'b0;
		txb_d         = 8'h00;
		done_d        = 1'b0;
		fault_d       = 1'b0;
		rword_d       = 32'h0;
		tout_d        = 32'h0;
		case (head_item.ev)
			isq_pkg::EV_START: begin
				if (phase_q != PH_IDLE) begin
					fault_d = 1'b1;
				end else begin
					addr_d        = head_item.dev_addr;
					dir_d         = head_item.read_mode;
					command_d     = head_item.command_word;
					reads_left_d  = head_item.read_extra;
					writes_left_d = head_item.write_extra;
					tag_d         = head_item.tag_in;
					accum_d       = '0;
					op_d          = isq_pkg::OP_START;
					txv_d         = 1'b1;
					txb_d         = {head_item.dev_addr, 1'b0};
					phase_d       = PH_INIT;
				end
			end
			isq_pkg::EV_ACK: begin
				case (phase_q)
					PH_INIT: begin
						txv_d = 1'b1;
						txb_d = command_q[8*writes_left_q +: 8];
						if (dir_q) begin
							if (writes_left_q == 2'd0) begin
								phase_d = PH_SETR;
							end else begin
								writes_left_d = wl_dec;
							end
						end else begin
							phase_d = (writes_left_q == 2'd0) ? PH_CLOSE : PH_WX;
						end
					end
					PH_WX: begin
						writes_left_d = wl_dec;
						txv_d         = 1'b1;
						txb_d         = command_q[8*wl_dec +: 8];
						if (wl_dec == 2'd0) begin
							phase_d = PH_CLOSE;
						end
					end
					PH_SETR: begin
						op_d    = isq_pkg::OP_START;
						txv_d   = 1'b1;
						txb_d   = {addr_q, 1'b1};
						phase_d = PH_HOLD;
					end
					PH_HOLD:  phase_d = PH_RX;
					PH_RX:    accum_d = '0;
					PH_CLOSE: op_d = isq_pkg::OP_STOP;
					default:  fault_d = 1'b1;
				endcase
			end
			isq_pkg::EV_NACK: begin
				if (phase_q == PH_HOLD) begin
					op_d  = isq_pkg::OP_START;
					txv_d = 1'b1;
					txb_d = {addr_q, 1'b1};
				end else begin
					fault_d = 1'b1;
				end
			end
			isq_pkg::EV_RX: begin
				if (phase_q == PH_RX) begin
					if (reads_left_q != 2'd0) begin
						accum_d      = acc_shift[AW-1:0];
						op_d         = isq_pkg::OP_ACK;
						reads_left_d = reads_left_q - 2'd1;
					end else begin
						accum_d = accum_q | AW'(head_item.rx_byte);
						op_d    = isq_pkg::OP_NSTOP;
						phase_d = PH_CLOSE;
					end
				end else begin
					fault_d = 1'b1;
				end
			end
			isq_pkg::EV_STOP: begin
				if (phase_q == PH_CLOSE) begin
					done_d  = 1'b1;
					rword_d = 32'(accum_q);
					tout_d  = tag_q;
					phase_d = PH_IDLE;
				end else begin
					fault_d = 1'b1;
				end
			end
			default: fault_d = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			addr_q        <= '0;
			dir_q         <= 1'b0;
			command_q     <= '0;
			writes_left_q <= '0;
			reads_left_q  <= '0;
			accum_q       <= '0;
			tag_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q       <= phase_d;
				addr_q        <= addr_d;
				dir_q         <= dir_d;
				command_q     <= command_d;
				writes_left_q <= writes_left_d;
				reads_left_q  <= reads_left_d;
				accum_q       <= accum_d;
				tag_q         <= tag_d;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bus_op_q    <= op_d;
			tx_valid_q  <= txv_d;
			tx_byte_q   <= txb_d;
			done_q      <= done_d;
			read_word_q <= rword_d;
			tag_out_q   <= tout_d;
			fault_q     <= fault_d;
			busy_q      <= (phase_d != PH_IDLE);
		end
	end

	assign out_valid = out_valid_q;
	assign bus_op    = bus_op_q;
	assign tx_valid  = tx_valid_q;
	assign tx_byte   = tx_byte_q;
	assign done_res  = done_q;
	assign read_word = read_word_q;
	assign tag_out   = tag_out_q;
	assign fault     = fault_q;
	assign busy_flag = busy_q;

endmodule

[rtl/i2c_sensor_transaction_sequencer_top.sv]
// i2c_sensor_transaction_sequencer_top: one result per bus event request
// a request is held in the queue entry, then the result in the isq_back output register
// a two-entry queue separates the decode front from the phase machine back
// one request per cycle sustained without out_stall, set by the phase update in isq_back
// arst_n clears phase to idle, all transaction registers to zero, queue empty
// depends on isq_pkg, isq_front, isq_queue, isq_back
module i2c_sensor_transaction_sequencer_top #(
	parameter int WORD_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [6:0]  dev_addr,
	input  logic        read_mode,
	input  logic [31:0] command_word,
	input  logic [1:0]  read_extra,
	input  logic [1:0]  write_extra,
	input  logic [31:0] tag_in,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  bus_op,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        done_res,
	output logic [31:0] read_word,
	output logic [31:0] tag_out,
	output logic        fault,
	output logic        busy_flag
);

	isq_pkg::item_t dec_item;
	isq_pkg::item_t head_item;
	logic           q_full;
	logic           head_valid;
	logic           pop;

	assign in_stall = q_full;

	isq_front u_front (
		.cmd          (cmd),
		.dev_addr     (dev_addr),
		.read_mode    (read_mode),
		.command_word (command_word),
		.read_extra   (read_extra),
		.write_extra  (write_extra),
		.tag_in       (tag_in),
		.rx_byte      (rx_byte),
		.item         (dec_item)
	);

	isq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !q_full),
		.push_item  (dec_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	isq_back #(
		.WORD_BYTES (WORD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bus_op     (bus_op),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.done_res   (done_res),
		.read_word  (read_word),
		.tag_out    (tag_out),
		.fault      (fault),
		.busy_flag  (busy_flag)
	);

endmodule

[tb/sv/tb_i2c_sensor_transaction_sequencer_top.sv]
// tb_i2c_sensor_transaction_sequencer_top: self-checking bench for the i2c transaction sequencer
// predicts one bus response per request and compares every response field in order
// depends on isq_pkg and i2c_sensor_transaction_sequencer_top
module tb_i2c_sensor_transaction_sequencer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] EV_LAST = 3'd7;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 10;

	typedef enum logic [2:0] {
		PH_IDLE, PH_ADDRESSED, PH_RESTART, PH_HOLD, PH_RECEIVE, PH_WRITE, PH_CLOSING
	} seq_phase_t;

	typedef struct packed {
		logic [2:0]  bus_op;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        done_res;
		logic [31:0] read_word;
		logic [31:0] tag_out;
		logic        fault;
		logic        busy_flag;
	} bus_resp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd          = '0;
	logic [6:0]  dev_addr     = '0;
	logic        read_mode    = 1'b0;
	logic [31:0] command_word = '0;
	logic [1:0]  read_extra   = '0;
	logic [1:0]  write_extra  = '0;
	logic [31:0] tag_in       = '0;
	logic [7:0]  rx_byte      = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  bus_op;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        done_res;
	logic [31:0] read_word;
	logic [31:0] tag_out;
	logic        fault;
	logic        busy_flag;

	i2c_sensor_transaction_sequencer_top u_dut (.*);

	// predictor state
	seq_phase_t  seq_phase   = PH_IDLE;
	logic [6:0]  addr_r      = '0;
	logic        read_dir_r  = 1'b0;
	logic [31:0] cmd_word_r  = '0;
	logic [1:0]  writes_left = '0;
	logic [1:0]  reads_left  = '0;
	logic [31:0] rx_word     = '0;
	logic [31:0] tag_r       = '0;

	isq_pkg::item_t pending_events[$];
	bus_resp_t      expected_responses[$];
	isq_pkg::item_t cur_req;
	int        events_queued   = 0;
	int        events_accepted = 0;
	int        mismatch_count  = 0;
	bit        req_taken       = 1'b0;
	bit        quiet           = 1'b0;
	bit        hold_off_req    = 1'b0;
	bit        hold_off_seen   = 1'b0;
	int        gap_left        = 0;
	int        stall_left      = 0;
	int        hold_left       = 0;
	int        idle_cycles     = 0;

	function automatic bus_resp_t predict_bus_response(isq_pkg::item_t r);
		bus_resp_t e;
		e = '0;
		case (r.ev)
			isq_pkg::EV_START: if (seq_phase != PH_IDLE) begin
				e.fault = 1'b1;
			end else begin
				addr_r      = r.dev_addr;
				read_dir_r  = r.read_mode;
				cmd_word_r  = r.command_word;
				reads_left  = r.read_extra;
				writes_left = r.write_extra;
				tag_r       = r.tag_in;
				rx_word     = '0;
				e.bus_op    = isq_pkg::OP_START;
				e.tx_valid  = 1'b1;
				e.tx_byte   = {addr_r, 1'b0};
				seq_phase   = PH_ADDRESSED;
			end
			isq_pkg::EV_ACK: case (seq_phase)
				PH_ADDRESSED: begin
					e.tx_valid = 1'b1;
					e.tx_byte  = cmd_word_r[writes_left*8 +: 8];
					if (read_dir_r) begin
						if (writes_left == 0)
							seq_phase = PH_RESTART;
						else
							writes_left = writes_left - 1'b1;
					end else begin
						seq_phase = (writes_left == 0) ? PH_CLOSING : PH_WRITE;
					end
				end
				PH_WRITE: begin
					writes_left = writes_left - 1'b1;
					e.tx_valid  = 1'b1;
					e.tx_byte   = cmd_word_r[writes_left*8 +: 8];
					if (writes_left == 0)
						seq_phase = PH_CLOSING;
				end
				PH_RESTART: begin
					e.bus_op   = isq_pkg::OP_START;
					e.tx_valid = 1'b1;
					e.tx_byte  = {addr_r, 1'b1};
					seq_phase  = PH_HOLD;
				end
				PH_HOLD:    seq_phase = PH_RECEIVE;
				PH_RECEIVE: rx_word = '0;
				PH_CLOSING: e.bus_op = isq_pkg::OP_STOP;
				default:    e.fault = 1'b1;
			endcase
			isq_pkg::EV_NACK: if (seq_phase == PH_HOLD) begin
				e.bus_op   = isq_pkg::OP_START;
				e.tx_valid = 1'b1;
				e.tx_byte  = {addr_r, 1'b1};
			end else begin
				e.fault = 1'b1;
			end
			isq_pkg::EV_RX: if (seq_phase == PH_RECEIVE) begin
				rx_word = rx_word | {24'h0, r.rx_byte};
				if (reads_left > 0) begin
					rx_word    = rx_word << 8;
					e.bus_op   = isq_pkg::OP_ACK;
					reads_left = reads_left - 1'b1;
				end else begin
					e.bus_op  = isq_pkg::OP_NSTOP;
					seq_phase = PH_CLOSING;
				end
			end else begin
				e.fault = 1'b1;
			end
			isq_pkg::EV_STOP: if (seq_phase == PH_CLOSING) begin
				e.done_res  = 1'b1;
				e.read_word = rx_word;
				e.tag_out   = tag_r;
				seq_phase   = PH_IDLE;
			end else begin
				e.fault = 1'b1;
			end
			default: e.fault = 1'b1;
		endcase
		e.busy_flag = (seq_phase != PH_IDLE);
		return e;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("response mismatch on %s: got %h, want %h",
				name, got, want));
	endtask

	function automatic isq_pkg::item_t random_event(logic [2:0] ev);
		isq_pkg::item_t r;
		r.ev           = ev;
		r.dev_addr     = 7'($urandom);
		r.read_mode    = 1'($urandom_range(0, 1));
		r.command_word = $urandom;
		r.read_extra   = 2'($urandom);
		r.write_extra  = 2'($urandom);
		r.tag_in       = $urandom;
		r.rx_byte      = 8'($urandom);
		return r;
	endfunction

	task automatic push_event(isq_pkg::item_t r);
		pending_events.push_back(r);
		events_queued++;
	endtask

	task automatic push_directed(logic [2:0] ev, logic [6:0] addr, logic rd, logic [31:0] cw,
			logic [1:0] re, logic [1:0] we, logic [31:0] tag, logic [7:0] rxb);
		push_event('{ev, addr, rd, cw, re, we, tag, rxb});
	endtask

	// occasionally a stray event lands ahead of the intended one
	task automatic queue_event(logic [2:0] ev);
		if ($urandom_range(0, 29) == 0)
			push_event(random_event(3'($urandom_range(isq_pkg::EV_START, EV_LAST))));
		push_event(random_event(ev));
	endtask

	task automatic queue_transaction();
		isq_pkg::item_t s;
		s = random_event(isq_pkg::EV_START);
		push_event(s);
		repeat (s.write_extra + 1) queue_event(isq_pkg::EV_ACK);
		if (s.read_mode) begin
			queue_event(isq_pkg::EV_ACK);
			repeat ($urandom_range(0, 2)) queue_event(isq_pkg::EV_NACK);
			queue_event(isq_pkg::EV_ACK);
			if ($urandom_range(0, 7) == 0)
				queue_event(isq_pkg::EV_ACK);
			repeat (s.read_extra + 1) queue_event(isq_pkg::EV_RX);
			if ($urandom_range(0, 1) == 0)
				queue_event(isq_pkg::EV_ACK);
		end else begin
			queue_event(isq_pkg::EV_ACK);
		end
		queue_event(isq_pkg::EV_STOP);
	endtask

	task automatic wait_all_answered();
		while (events_accepted != events_queued || expected_responses.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (!quiet && pending_events.size() > 0 && $urandom_range(0, 11) == 0) begin
				in_valid <= 1'b0;
				gap_left = $urandom_range(0, 12);
			end else if (pending_events.size() > 0) begin
				cur_req = pending_events.pop_front();
				in_valid <= 1'b1;
				{cmd, dev_addr, read_mode, command_word, read_extra, write_extra, tag_in, rx_byte}
					<= cur_req;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// response receiver
	always @(negedge clk) begin
		if (hold_off_req && !hold_off_seen) begin
			hold_off_seen = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		bus_resp_t want;
		req_taken = in_valid && !in_stall;
		if (arst_n) begin
			if (req_taken) begin
				expected_responses.push_back(predict_bus_response(cur_req));
				events_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = expected_responses.pop_front();
					compare_field("bus_op", 32'(bus_op), 32'(want.bus_op));
					compare_field("tx_valid", 32'(tx_valid), 32'(want.tx_valid));
					compare_field("tx_byte", 32'(tx_byte), 32'(want.tx_byte));
					compare_field("done_res", 32'(done_res), 32'(want.done_res));
					compare_field("read_word", read_word, want.read_word);
					compare_field("tag_out", tag_out, want.tag_out);
					compare_field("fault", 32'(fault), 32'(want.fault));
					compare_field("busy_flag", 32'(busy_flag), 32'(want.busy_flag));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// events with no meaning while idle, unknown codes
		push_directed(isq_pkg::EV_ACK, 7'h7F, 1'b1, 32'hFFFFFFFF, 2'd3, 2'd3, 32'hFFFFFFFF,
			8'hFF);
		push_directed(isq_pkg::EV_NACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_RX, '0, 1'b0, '0, '0, '0, '0, 8'hFF);
		push_directed(isq_pkg::EV_STOP, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_BAD, 7'h55, 1'b1, 32'h12345678, 2'd1, 2'd2, 32'h1, 8'h1);
		push_directed(EV_LAST, '0, 1'b0, '0, '0, '0, '0, '0);
		// single byte write, start while busy
		push_directed(isq_pkg::EV_START, 7'h7F, 1'b0, 32'hA1B2C3D4, 2'd3, 2'd0, 32'hFFFFFFFF,
			8'h00);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_START, 7'h01, 1'b1, 32'h0, 2'd0, 2'd3, 32'h5, 8'h00);
		push_directed(isq_pkg::EV_STOP, '0, 1'b0, '0, '0, '0, '0, '0);
		// read with retry, word clear in receive, extra stop
		push_directed(isq_pkg::EV_START, 7'h00, 1'b1, 32'hFFFFFFFF, 2'd3, 2'd1, 32'h0, 8'h00);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_NACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_NACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_RX, '0, 1'b0, '0, '0, '0, '0, 8'hFF);
		push_directed(isq_pkg::EV_RX, '0, 1'b0, '0, '0, '0, '0, 8'h00);
		push_directed(isq_pkg::EV_RX, '0, 1'b0, '0, '0, '0, '0, 8'h5A);
		push_directed(isq_pkg::EV_RX, '0, 1'b0, '0, '0, '0, '0, 8'hA5);
		push_directed(isq_pkg::EV_ACK, '0, 1'b0, '0, '0, '0, '0, '0);
		push_directed(isq_pkg::EV_STOP, '0, 1'b0, '0, '0, '0, '0, '0);
		wait_all_answered();

		while (events_queued < 650)
			queue_transaction();
		hold_off_req = 1'b1;
		wait_all_answered();

		while (events_queued < 1000)
			queue_transaction();
		while (pending_events.size() > 300)
			@(posedge clk);
		quiet = 1'b1;
		while (events_queued < 1325)
			queue_transaction();
		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
